>>> sv/archive_header_scan_skip_top_macros.svh
// Assertion macros for the archive header scan block checker.
// Each macro expands to one labeled concurrent assertion clocked by clk.
`ifndef ARCHIVE_HEADER_SCAN_SKIP_TOP_MACROS_SVH
`define ARCHIVE_HEADER_SCAN_SKIP_TOP_MACROS_SVH

// checked only outside reset
`define AHSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked at every edge, reset included
`define AHSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/ahss_pkg.sv
// Shared types, constants and match functions for the archive header scan block.
// No dependencies.
`default_nettype none

package ahss_pkg;

  localparam int POSITION_BITS = 14;
  localparam int WIN_LEN       = 13;
  localparam int ID_LEN        = 12;
  localparam int DATA_W        = 8;
  localparam int OFFSET_W      = 14;
  localparam int LIMIT_W       = 14;
  localparam int CNT_W         = $clog2(WIN_LEN + 1);
  localparam int CMP_W         = (POSITION_BITS > LIMIT_W) ? POSITION_BITS : LIMIT_W;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_IDX_W     = CFG_ADDR_W - 2;

  localparam logic [LIMIT_W-1:0]   LIMIT_RESET    = LIMIT_W'(8192);
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_LIMIT = CFG_IDX_W'(0);

  localparam logic [DATA_W-1:0] CH_DASH = 8'h2D;
  localparam logic [DATA_W-1:0] CH_L    = 8'h6C;
  localparam logic [DATA_W-1:0] CH_H    = 8'h68;
  localparam logic [DATA_W-1:0] CH_Z    = 8'h7A;
  localparam logic [DATA_W-1:0] CH_4    = 8'h34;
  localparam logic [DATA_W-1:0] CH_5    = 8'h35;
  localparam logic [DATA_W-1:0] CH_S    = 8'h73;
  localparam logic [DATA_W-1:0] CH_P    = 8'h70;
  localparam logic [DATA_W-1:0] CH_M    = 8'h6D;

  // self-extractor ID, element 0 is the first byte of the ID
  localparam logic [ID_LEN-1:0][DATA_W-1:0] SFX_ID = {
    8'h2C, 8'h32, 8'h2E, 8'h31, 8'h56, 8'h20,
    8'h58, 8'h46, 8'h53, 8'h41, 8'h68, 8'h4C
  };

  // element 0 is the oldest byte
  typedef logic [WIN_LEN-1:0][DATA_W-1:0] win_t;

  typedef enum logic [1:0] {
    MODE_SCAN,
    MODE_PASS,
    MODE_FAILED
  } mode_t;

  typedef struct packed {
    logic                load;
    logic [CNT_W-1:0]    count;
    win_t                bytes;
    logic                status;
    logic [OFFSET_W-1:0] offset;
    logic                stream_end;
  } burst_load_t;

  function automatic logic is_header(win_t w);
    logic dashes;
    logic lh;
    logic lz;
    logic pm;
    dashes = (w[2] == CH_DASH) && (w[6] == CH_DASH);
    lh = (w[3] == CH_L) && (w[4] == CH_H);
    lz = (w[3] == CH_L) && (w[4] == CH_Z) &&
         ((w[5] == CH_4) || (w[5] == CH_5) || (w[5] == CH_S));
    pm = (w[3] == CH_P) && (w[4] == CH_M) && (w[5] != CH_S);
    return dashes && (lh || lz || pm);
  endfunction

  function automatic logic is_sfx(win_t w);
    logic hit;
    hit = 1'b1;
    for (int i = 0; i < ID_LEN; i++) begin
      hit = hit && (w[i] == SFX_ID[i]);
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

>>> sv/ahss_in_if.sv
// Input byte channel: valid/ready plus one stream byte and its end flag.
// Depends on ahss_pkg.
`default_nettype none

interface ahss_in_if;
  import ahss_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

`default_nettype wire

>>> sv/ahss_out_if.sv
// Result channel: valid/ready plus one output byte with status and framing flags.
// Depends on ahss_pkg.
`default_nettype none

interface ahss_out_if;
  import ahss_pkg::*;

  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   out_byte;
  logic                status;
  logic [OFFSET_W-1:0] header_offset;
  logic                run_last;
  logic                stream_end;

  modport source (output valid, output out_byte, output status, output header_offset,
                  output run_last, output stream_end, input ready);
  modport sink   (input valid, input out_byte, input status, input header_offset,
                  input run_last, input stream_end, output ready);
endinterface

`default_nettype wire

>>> sv/ahss_burst.sv
// Result register: holds one result or a 13-byte header burst and shifts it out.
// Depends on ahss_pkg and ahss_out_if.
`default_nettype none

module ahss_burst (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire ahss_pkg::burst_load_t ld,
  output logic                  free,
  ahss_out_if.source            out_res
);
  import ahss_pkg::*;

  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  win_t                buf_r, buf_nxt;
  logic                status_r, status_nxt;
  logic [OFFSET_W-1:0] off_r, off_nxt;
  logic                se_r, se_nxt;
  logic                pop;

  assign pop  = (cnt_r != '0) && out_res.ready;
  assign free = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_res.ready);

  always_comb begin
    cnt_nxt    = cnt_r;
    buf_nxt    = buf_r;
    status_nxt = status_r;
    off_nxt    = off_r;
    se_nxt     = se_r;
    if (pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      buf_nxt = win_t'(buf_r >> DATA_W);
    end
    if (ld.load) begin
      cnt_nxt    = ld.count;
      buf_nxt    = ld.bytes;
      status_nxt = ld.status;
      off_nxt    = ld.offset;
      se_nxt     = ld.stream_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r    <= buf_nxt;
    status_r <= status_nxt;
    off_r    <= off_nxt;
    se_r     <= se_nxt;
  end

  assign out_res.valid         = (cnt_r != '0);
  assign out_res.out_byte      = buf_r[0];
  assign out_res.status        = status_r;
  assign out_res.header_offset = off_r;
  assign out_res.run_last      = (cnt_r == CNT_W'(1));
  assign out_res.stream_end    = se_r && (cnt_r == CNT_W'(1));

endmodule

`default_nettype wire

>>> sv/archive_header_scan_skip_top.sv
// Archive header scanner: finds the first member header in a byte stream and
// passes the archive from there. Depends on ahss_pkg, ahss_in_if, ahss_out_if, ahss_burst.
//
// Usage:
//   in_req takes one stream byte per request, is_last marks the final byte.
//   out_res gives result requests: payload bytes from the header start on, or
//   a single failure result (status 1) when no header turns up in scan_limit
//   positions or the stream ends first.
//   cfg_* is an APB-style port; scan_limit sits at byte address 0.
// Timing:
//   One byte accepted per cycle while in_req.ready is high; a result appears
//   in the cycle after its byte. A header match emits the 13 window bytes
//   from the output shift register, and in_req.ready stays low until the
//   last of them is being taken. in_req.ready follows out_res.ready in the
//   same cycle when the last held result is being taken.
// Reset (rst_n, synchronous): scanning restarts, the result register empties
//   and scan_limit returns to 8192. A stalled receiver holds the current
//   result and stops input once the result register is full.
`default_nettype none

module archive_header_scan_skip_top (
  input  wire                              clk,
  input  wire                              rst_n,
  ahss_in_if.sink                          in_req,
  ahss_out_if.source                       out_res,
  input  wire                              cfg_psel,
  input  wire                              cfg_penable,
  input  wire                              cfg_pwrite,
  input  wire  [ahss_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire  [ahss_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [ahss_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import ahss_pkg::*;

  win_t                     win_r, win_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic [POSITION_BITS-1:0] bcnt_r, bcnt_nxt;
  logic                     skip_r, skip_nxt;
  mode_t                    mode_r, mode_nxt;
  logic [OFFSET_W-1:0]      foff_r, foff_nxt;
  logic [LIMIT_W-1:0]       limit_r;

  logic                     accept;
  logic                     free;
  win_t                     win_shift;
  logic [CNT_W-1:0]         fill_inc;
  logic [POSITION_BITS-1:0] bcnt_inc;
  logic                     examine;
  logic                     hdr;
  logic                     sfx;
  logic                     take_hdr;
  logic                     limit_hit;
  logic [CFG_IDX_W-1:0]     cfg_idx;
  burst_load_t              ld;

  assign in_req.ready = free;
  assign accept       = in_req.valid && free;

  assign win_shift = win_t'({in_req.data_byte, win_r[WIN_LEN-1:1]});
  assign fill_inc  = (fill_r < CNT_W'(WIN_LEN)) ? fill_r + CNT_W'(1) : fill_r;
  assign bcnt_inc  = (bcnt_r != '1) ? bcnt_r + POSITION_BITS'(1) : bcnt_r;
  assign examine   = (mode_r == MODE_SCAN) && (fill_inc == CNT_W'(WIN_LEN));
  assign hdr       = is_header(win_shift);
  assign sfx       = is_sfx(win_shift);
  assign take_hdr  = examine && hdr && !skip_r;
  assign limit_hit = examine && !take_hdr && (CMP_W'(bcnt_inc) >= CMP_W'(limit_r));

  // next state
  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    bcnt_nxt = bcnt_r;
    skip_nxt = skip_r;
    mode_nxt = mode_r;
    foff_nxt = foff_r;
    if (accept) begin
      if (mode_r == MODE_SCAN) begin
        win_nxt  = win_shift;
        fill_nxt = fill_inc;
        if (examine) begin
          bcnt_nxt = bcnt_inc;
          if (hdr && skip_r) begin
            skip_nxt = 1'b0;
          end
          if (!take_hdr && sfx) begin
            skip_nxt = 1'b1;
          end
          if (take_hdr) begin
            mode_nxt = MODE_PASS;
            foff_nxt = OFFSET_W'(bcnt_r);
          end else if (limit_hit) begin
            mode_nxt = MODE_FAILED;
          end
        end
      end
      if (in_req.is_last) begin
        fill_nxt = '0;
        bcnt_nxt = '0;
        skip_nxt = 1'b0;
        mode_nxt = MODE_SCAN;
      end
    end
  end

  // results
  always_comb begin
    ld = '0;
    if (accept) begin
      case (mode_r)
        MODE_PASS: begin
          ld.load       = 1'b1;
          ld.count      = CNT_W'(1);
          ld.bytes[0]   = in_req.data_byte;
          ld.offset     = foff_r;
          ld.stream_end = in_req.is_last;
        end
        MODE_SCAN: begin
          if (take_hdr) begin
            ld.load       = 1'b1;
            ld.count      = CNT_W'(WIN_LEN);
            ld.bytes      = win_shift;
            ld.offset     = OFFSET_W'(bcnt_r);
            ld.stream_end = in_req.is_last;
          end else if (limit_hit || in_req.is_last) begin
            ld.load       = 1'b1;
            ld.count      = CNT_W'(1);
            ld.status     = 1'b1;
            ld.stream_end = 1'b1;
          end
        end
        default: begin
          ld = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      bcnt_r <= '0;
      skip_r <= 1'b0;
      mode_r <= MODE_SCAN;
    end else begin
      fill_r <= fill_nxt;
      bcnt_r <= bcnt_nxt;
      skip_r <= skip_nxt;
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    foff_r <= foff_nxt;
  end

  // configuration
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_idx == REG_SCAN_LIMIT) ? CFG_DATA_W'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_idx == REG_SCAN_LIMIT)) begin
      limit_r <= cfg_pwdata[LIMIT_W-1:0];
    end
  end

  ahss_burst u_burst (
    .clk     (clk),
    .rst_n   (rst_n),
    .ld      (ld),
    .free    (free),
    .out_res (out_res)
  );

endmodule

`default_nettype wire

>>> sv/ahss_chk.sv
// Port-level checker for archive_header_scan_skip_top, bound to the top level.
// Depends on ahss_pkg and archive_header_scan_skip_top_macros.svh.
`default_nettype none
`include "archive_header_scan_skip_top_macros.svh"

module ahss_chk (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [ahss_pkg::DATA_W-1:0]   out_byte,
  input wire                          out_status,
  input wire [ahss_pkg::OFFSET_W-1:0] out_header_offset,
  input wire                          out_run_last,
  input wire                          out_stream_end
);
  import ahss_pkg::*;

  `AHSS_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result pending after reset")

  `AHSS_ASSERT(a_fail_form, out_valid && out_status |-> out_run_last && out_stream_end && (out_byte == '0) && (out_header_offset == '0), "malformed failure result")

  `AHSS_ASSERT(a_end_last, out_valid && out_stream_end |-> out_run_last, "stream end not on last result")

  `AHSS_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_header_offset), "stalled result changed")

endmodule

bind archive_header_scan_skip_top ahss_chk u_ahss_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_res.valid),
  .out_ready         (out_res.ready),
  .out_byte          (out_res.out_byte),
  .out_status        (out_res.status),
  .out_header_offset (out_res.header_offset),
  .out_run_last      (out_res.run_last),
  .out_stream_end    (out_res.stream_end)
);

`default_nettype wire
